/* hw/rtl/srws_pkg.sv */
// Shared constants, types and helper functions for the scaled reading window statistics core.
package srws_pkg;

  localparam int unsigned WindowDefault = 100;
  localparam int unsigned CfgWidth = 24;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned RawWidth = 16;
  localparam int unsigned ValWidth = 32;
  localparam int unsigned DecWidth = 3;
  localparam int unsigned DivWidth = 24;
  localparam int unsigned DivDefault = 256;
  localparam int unsigned MaxDecimals = 4;

  // Reciprocals for division by a constant are scaled by two to the power RecipShift.
  localparam int unsigned RecipShift = 36;
  localparam longint unsigned RecipOne = 64'd1 << RecipShift;
  localparam logic [36:0] Recip5 = 37'((RecipOne + 64'd4) / 64'd5);

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgDivider   = 3'd0,
    CfgDecimals  = 3'd1,
    CfgSignedRaw = 3'd2,
    CfgIsTemp    = 3'd3,
    CfgFahr      = 3'd4,
    CfgLogEnable = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [DivWidth-1:0] divider_q8;
    logic [DecWidth-1:0] decimals;
    logic                signed_raw;
    logic                is_temperature;
    logic                fahrenheit;
    logic                log_enable;
  } cfg_t;

  function automatic logic [13:0] pow10(input logic [DecWidth-1:0] dec);
    logic [13:0] p;
    unique case (dec)
      3'd0: p = 14'd1;
      3'd1: p = 14'd10;
      3'd2: p = 14'd100;
      3'd3: p = 14'd1000;
      default: p = 14'd10000;
    endcase
    return p;
  endfunction

  function automatic logic [36:0] recip_pow10(input logic [DecWidth-1:0] dec);
    logic [36:0] m;
    unique case (dec)
      3'd0: m = 37'(RecipOne);
      3'd1: m = 37'((RecipOne + 64'd9) / 64'd10);
      3'd2: m = 37'((RecipOne + 64'd99) / 64'd100);
      3'd3: m = 37'((RecipOne + 64'd999) / 64'd1000);
      default: m = 37'((RecipOne + 64'd9999) / 64'd10000);
    endcase
    return m;
  endfunction

  function automatic logic signed [ValWidth-1:0] sat32(input logic signed [63:0] x);
    logic signed [ValWidth-1:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = x[ValWidth-1:0];
    end
    return r;
  endfunction

  typedef enum logic [3:0] {
    StIdle,
    StDiv1,
    StFahr,
    StDiv2,
    StWhole,
    StDiv3,
    StMemRd,
    StMemWr,
    StScan,
    StAvg,
    StDiv4,
    StOut
  } state_e;

endpackage

/* hw/rtl/srws_divider.sv */
// Signed bit-serial restoring division by a 32-bit divisor, with optional flooring.
module srws_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                floor_i,
  input  logic signed [63:0]  num_i,
  input  logic [31:0]         den_i,
  output logic                done_o,
  output logic signed [63:0]  quo_o
);
  import srws_pkg::*;

  logic [63:0] n_q, n_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d, flr_q, flr_d, done_q, done_d;
  logic [32:0] trial;
  logic [63:0] mag;
  logic [63:0] q_adj;

  always_comb begin
    n_d = n_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; flr_d = flr_q; done_d = 1'b0;
    mag = num_i[63] ? (~num_i + 64'd1) : num_i;
    trial = {rem_q[31:0], n_q[63]} - {1'b0, den_q};
    if (start_i) begin
      n_d = mag; rem_d = '0; den_d = den_i; cnt_d = 7'd64;
      busy_d = 1'b1; neg_d = num_i[63]; flr_d = floor_i;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial;
        n_d = {n_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], n_q[63]};
        n_d = {n_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_comb begin
    q_adj = n_q + ((neg_q && flr_q && (rem_q != '0)) ? 64'd1 : 64'd0);
    quo_o = neg_q ? -$signed(q_adj) : $signed(q_adj);
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; rem_q <= rem_d; den_q <= den_d;
    neg_q <= neg_d; flr_q <= flr_d;
  end
endmodule

module srws_const_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               floor_i,
  input  logic signed [63:0] num_i,
  input  logic [13:0]        den_i,
  input  logic [36:0]        recip_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);
  import srws_pkg::*;

  logic [39:0] mag;
  logic [39:0] n_q, n_d, quo_q, quo_d;
  logic [13:0] rem_q, rem_d, den_q, den_d;
  logic [36:0] recip_q, recip_d;
  logic [21:0] t, t_q, t_d;
  logic [7:0]  qd_q, qd_d;
  logic [58:0] prod;
  logic [21:0] qd_den, rem_full;
  logic [2:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, phase_q, phase_d, done_q, done_d;
  logic        neg_q, neg_d, flr_q, flr_d;
  logic [40:0] q_adj;
  logic [63:0] q_ext;

  always_comb begin
    n_d = n_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q; recip_d = recip_q;
    t_d = t_q; qd_d = qd_q; cnt_d = cnt_q; busy_d = busy_q; phase_d = phase_q;
    done_d = 1'b0; neg_d = neg_q; flr_d = flr_q;
    mag = num_i[63] ? (~num_i[39:0] + 40'd1) : num_i[39:0];
    t = {rem_q, n_q[39:32]};
    prod = {37'd0, t} * {22'd0, recip_q};
    qd_den = {14'd0, qd_q} * {8'd0, den_q};
    rem_full = t_q - qd_den;
    if (start_i) begin
      n_d = mag; quo_d = '0; rem_d = '0; den_d = den_i; recip_d = recip_i;
      cnt_d = 3'd5; busy_d = 1'b1; phase_d = 1'b0;
      neg_d = num_i[63]; flr_d = floor_i;
    end else if (busy_q) begin
      if (!phase_q) begin
        t_d = t;
        qd_d = prod[RecipShift+7:RecipShift];
        n_d = {n_q[31:0], 8'd0};
        phase_d = 1'b1;
      end else begin
        rem_d = rem_full[13:0];
        quo_d = {quo_q[31:0], qd_q};
        phase_d = 1'b0;
        cnt_d = cnt_q - 3'd1;
        if (cnt_q == 3'd1) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    q_adj = {1'b0, quo_q} + ((neg_q && flr_q && (rem_q != '0)) ? 41'd1 : 41'd0);
    q_ext = {23'd0, q_adj};
    quo_o = neg_q ? -$signed(q_ext) : $signed(q_ext);
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d; recip_q <= recip_d;
    t_q <= t_d; qd_q <= qd_d; neg_q <= neg_d; flr_q <= flr_d;
  end
endmodule

/* hw/rtl/srws_window_mem.sv */
// Window memory with synchronous read and write, one port each.
module srws_window_mem #(
  parameter int unsigned Window = srws_pkg::WindowDefault,
  localparam int unsigned AddrW = $clog2(Window)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AddrW-1:0]             waddr_i,
  input  logic signed [srws_pkg::ValWidth-1:0] wdata_i,
  input  logic [AddrW-1:0]             raddr_i,
  output logic signed [srws_pkg::ValWidth-1:0] rdata_o
);
  import srws_pkg::*;

  logic signed [ValWidth-1:0] mem [Window];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

/* hw/rtl/scaled_reading_window_stats_core.sv */
// Scaled reading window statistics core: scaling, Fahrenheit conversion and window stats.
// Each transfer is processed alone. Once the result has been loaded into the output
// register, the next transfer can be accepted at the following edge. The work is the
// 64-step bit-serial division by divider_q8, up to three divisions by constants on byte
// chunks (the division by five only when the Fahrenheit conversion runs) and, with logging
// on, the sweep of the window memory one entry per cycle. After reset the core clears
// every entry of the window memory before it accepts the first transfer. A result that has
// not been taken holds the core in its last step.
module scaled_reading_window_stats_core #(
  parameter int unsigned Window = srws_pkg::WindowDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [srws_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [srws_pkg::CfgWidth-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [15:0]                    raw_sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             scaled_value_o,
  output logic signed [31:0]             whole_part_o,
  output logic                           changed_o,
  output logic signed [31:0]             window_average_o,
  output logic signed [31:0]             window_minimum_o,
  output logic signed [31:0]             window_maximum_o
);
  import srws_pkg::*;

  localparam int unsigned AddrW = $clog2(Window);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Window - 1);
  localparam logic [13:0] WindowDen = 14'(Window);
  localparam logic [36:0] WindowRecip = 37'((RecipOne + 64'(Window) - 64'd1) / 64'(Window));

  cfg_t cfg_q;
  state_e st_q, st_d;
  logic clr_q, clr_d;
  logic [AddrW-1:0] wp_q, wp_d, addr_q, addr_d;
  logic signed [39:0] sum_q, sum_d;
  logic [15:0] raw_q, raw_d, prev_q, prev_d;
  logic first_q, first_d, chg_q, chg_d;
  logic signed [31:0] v_q, v_d, whole_q, whole_d, mn_q, mn_d, mx_q, mx_d, avg_q, avg_d;
  logic signed [63:0] prod_q, prod_d;
  logic ovalid_q, ovalid_d;
  logic signed [31:0] scaled_q, scaled_d, wholeo_q, wholeo_d, avgo_q, avgo_d;
  logic signed [31:0] mino_q, mino_d, maxo_q, maxo_d;
  logic changedo_q, changedo_d;

  logic div_start, div_done;
  logic signed [63:0] dnum, dquo;
  logic [31:0] dden;
  logic dfloor;

  logic cd_start, cd_done, cd_floor;
  logic signed [63:0] cd_num, cd_quo;
  logic [13:0] cd_den;
  logic [36:0] cd_recip;

  logic mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic signed [31:0] mem_wdata, mem_rdata;
  logic scan_valid_q, scan_valid_d;

  logic [DecWidth-1:0] dec_c;
  logic [13:0] scale;
  logic signed [16:0] rsx;

  assign dec_c = (cfg_q.decimals > 3'd4) ? 3'd4 : cfg_q.decimals;
  assign scale = pow10(dec_c);
  assign rsx = (cfg_q.signed_raw && raw_q[15]) ? {1'b1, raw_q} : {1'b0, raw_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{divider_q8: DivWidth'(DivDefault), decimals: '0, signed_raw: 1'b0,
                 is_temperature: 1'b0, fahrenheit: 1'b0, log_enable: 1'b0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDivider:   cfg_q.divider_q8 <= cfg_data_i;
        CfgDecimals:  cfg_q.decimals <= cfg_data_i[DecWidth-1:0];
        CfgSignedRaw: cfg_q.signed_raw <= cfg_data_i[0];
        CfgIsTemp:    cfg_q.is_temperature <= cfg_data_i[0];
        CfgFahr:      cfg_q.fahrenheit <= cfg_data_i[0];
        CfgLogEnable: cfg_q.log_enable <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  srws_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .floor_i(dfloor), .num_i(dnum),
    .den_i(dden), .done_o(div_done), .quo_o(dquo)
  );

  srws_const_div u_cdiv (
    .clk_i, .rst_ni, .start_i(cd_start), .floor_i(cd_floor), .num_i(cd_num),
    .den_i(cd_den), .recip_i(cd_recip), .done_o(cd_done), .quo_o(cd_quo)
  );

  srws_window_mem #(.Window(Window)) u_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata)
  );

  always_comb begin
    st_d = st_q; clr_d = clr_q; wp_d = wp_q; addr_d = addr_q; sum_d = sum_q;
    raw_d = raw_q; prev_d = prev_q; first_d = first_q; chg_d = chg_q;
    v_d = v_q; whole_d = whole_q; mn_d = mn_q; mx_d = mx_q; avg_d = avg_q;
    prod_d = prod_q; scan_valid_d = 1'b0;
    ovalid_d = ovalid_q; scaled_d = scaled_q; wholeo_d = wholeo_q; avgo_d = avgo_q;
    mino_d = mino_q; maxo_d = maxo_q; changedo_d = changedo_q;
    div_start = 1'b0; dnum = prod_q; dfloor = 1'b1;
    dden = {8'd0, (cfg_q.divider_q8 == '0) ? 24'd1 : cfg_q.divider_q8};
    cd_start = 1'b0; cd_num = prod_q; cd_den = scale; cd_recip = recip_pow10(dec_c);
    cd_floor = 1'b1;
    mem_we = 1'b0; mem_waddr = addr_q; mem_wdata = '0; mem_raddr = addr_q;
    in_ready_o = 1'b0;

    if (out_ready_i) begin
      ovalid_d = 1'b0;
    end

    if (clr_q) begin
      mem_we = 1'b1;
      addr_d = addr_q + AddrW'(1);
      if (addr_q == LastAddr) begin
        clr_d = 1'b0;
        addr_d = '0;
      end
    end

    unique case (st_q)
      StIdle: begin
        in_ready_o = !clr_q;
        if (in_valid_i && !clr_q) begin
          raw_d = raw_sample_i;
          chg_d = (raw_sample_i != prev_q) || first_q;
          prev_d = raw_sample_i;
          first_d = 1'b0;
          st_d = StDiv1;
        end
      end
      StDiv1: begin
        dnum = 64'(rsx * $signed({1'b0, scale}) * 64'sd256);
        div_start = 1'b1;
        st_d = StFahr;
      end
      StFahr: begin
        if (div_done) begin
          v_d = sat32(dquo);
          prod_d = 64'(sat32(dquo)) * 64'sd9;
          st_d = (cfg_q.is_temperature && cfg_q.fahrenheit) ? StDiv2 : StWhole;
        end
      end
      StDiv2: begin
        cd_num = prod_q;
        cd_den = 14'd5;
        cd_recip = Recip5;
        cd_start = 1'b1;
        st_d = StWhole;
      end
      StWhole: begin
        if (cfg_q.is_temperature && cfg_q.fahrenheit) begin
          if (cd_done) begin
            v_d = sat32(cd_quo + 64'($signed({1'b0, scale})) * 64'sd32);
            st_d = StDiv3;
          end
        end else begin
          st_d = StDiv3;
        end
      end
      StDiv3: begin
        cd_num = 64'(v_q);
        cd_floor = 1'b0;
        cd_start = 1'b1;
        st_d = StMemRd;
      end
      StMemRd: begin
        if (cd_done) begin
          whole_d = cd_quo[31:0];
          if (cfg_q.log_enable) begin
            addr_d = wp_q;
            st_d = StMemWr;
          end else begin
            avg_d = '0; mn_d = '0; mx_d = '0;
            st_d = StOut;
          end
        end
      end
      StMemWr: begin
        mem_raddr = wp_q;
        if (scan_valid_q) begin
          sum_d = sum_q - 40'(mem_rdata) + 40'(v_q);
          mem_we = 1'b1;
          mem_waddr = wp_q;
          mem_wdata = v_q;
          wp_d = (wp_q == LastAddr) ? '0 : wp_q + AddrW'(1);
          addr_d = '0;
          mn_d = 32'sh7FFF_FFFF;
          mx_d = -32'sh8000_0000;
          st_d = StScan;
        end else begin
          scan_valid_d = 1'b1;
        end
      end
      StScan: begin
        mem_raddr = addr_q;
        scan_valid_d = 1'b1;
        if (scan_valid_q) begin
          if (mem_rdata < mn_q) mn_d = mem_rdata;
          if (mem_rdata > mx_q) mx_d = mem_rdata;
        end
        if (addr_q == LastAddr) begin
          st_d = StAvg;
        end else begin
          addr_d = addr_q + AddrW'(1);
        end
      end
      StAvg: begin
        if (mem_rdata < mn_q) mn_d = mem_rdata;
        if (mem_rdata > mx_q) mx_d = mem_rdata;
        cd_num = 64'(sum_q);
        cd_den = WindowDen;
        cd_recip = WindowRecip;
        cd_start = 1'b1;
        st_d = StDiv4;
      end
      StDiv4: begin
        if (cd_done) begin
          avg_d = sat32(cd_quo);
          st_d = StOut;
        end
      end
      StOut: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          scaled_d = v_q; wholeo_d = whole_q; changedo_d = chg_q;
          avgo_d = avg_q; mino_d = mn_q; maxo_d = mx_q;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; clr_q <= 1'b1; wp_q <= '0; addr_q <= '0; sum_q <= '0;
      prev_q <= '0; first_q <= 1'b1; ovalid_q <= 1'b0; scan_valid_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; wp_q <= wp_d; addr_q <= addr_d; sum_q <= sum_d;
      prev_q <= prev_d; first_q <= first_d; ovalid_q <= ovalid_d;
      scan_valid_q <= scan_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q <= raw_d; chg_q <= chg_d; v_q <= v_d; whole_q <= whole_d;
    mn_q <= mn_d; mx_q <= mx_d; avg_q <= avg_d; prod_q <= prod_d;
    scaled_q <= scaled_d; wholeo_q <= wholeo_d; avgo_q <= avgo_d;
    mino_q <= mino_d; maxo_q <= maxo_d; changedo_q <= changedo_d;
  end

  assign out_valid_o = ovalid_q;
  assign scaled_value_o = scaled_q;
  assign whole_part_o = wholeo_q;
  assign changed_o = changedo_q;
  assign window_average_o = avgo_q;
  assign window_minimum_o = mino_q;
  assign window_maximum_o = maxo_q;
endmodule

/* hw/rtl/srws_checker.sv */
// Port-level checker for the scaled reading window statistics core and its bind.
module srws_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] scaled_value_o,
  input logic signed [31:0] window_minimum_o,
  input logic signed [31:0] window_maximum_o
);
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Core accepted a transfer while busy.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(scaled_value_o))
    else $error("Result changed while stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_minimum_o <= window_maximum_o)
    else $error("Window minimum exceeds maximum.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o || $past(out_valid_o))
    else $error("Result appeared too early.");
endmodule

bind scaled_reading_window_stats_core srws_checker u_srws_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .scaled_value_o, .window_minimum_o, .window_maximum_o
);
